// File: sv/b93crc_pkg.sv
package b93crc_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_CORRUPTED = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  localparam logic [7:0] CharSkip  = 8'h2B;
  localparam logic [8:0] CharBase  = 9'd33;
  localparam logic [7:0] CrcPoly   = 8'h1D;
  localparam logic [7:0] CrcInit   = 8'hFF;
  localparam logic [2:0] LastDigit = 3'd4;
  localparam logic [2:0] TailPos   = 3'd4;

  // One entry of the queue between front and back end.
  typedef struct packed {
    logic [31:0] group;
    logic        has_group;
    logic        last;
  } rec_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        dir;
    logic [6:0]  pid;
    status_e     status;
    logic        last_of_run;
  } result_t;

  function automatic logic [26:0] weight93(input logic [2:0] idx);
    logic [26:0] w;
    unique case (idx)
      3'd0:    w = 27'd1;
      3'd1:    w = 27'd93;
      3'd2:    w = 27'd8649;
      3'd3:    w = 27'd804357;
      3'd4:    w = 27'd74805201;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

  // CRC-8 with polynomial 0x1D, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: sv/base93_crc8_packet_decoder_unit.sv
// Base-93 packet decoder with CRC-8 check. One character is taken per clock while the
// record queue has room; every fifth character, or a character marked last, places one
// record in that queue. The back end retires records at one result per clock while the
// result queue has room (header, length, payload bytes, final status), and the record
// queue absorbs the difference. A group's record is registered in the record queue, and
// its first result then in the result queue, before that result appears on the result port.
// The payload_capacity register is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module base93_crc8_packet_decoder_unit #(
  parameter int REC_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       last_char_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] data_value_o,
  output logic       direction_o,
  output logic [6:0] packet_id_o,
  output logic [1:0] status_o,
  output logic       last_of_run_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i
);

  localparam int RecW = $bits(b93crc_pkg::rec_t);
  localparam int ResW = $bits(b93crc_pkg::result_t);

  logic [8:0]           cap_q;
  logic                 take;
  logic                 rec_push, rec_pop, rec_full, rec_empty;
  b93crc_pkg::rec_t     rec_in, rec_out;
  logic [RecW-1:0]      rec_out_vec;
  logic                 out_push, out_full;
  b93crc_pkg::result_t  res_in, res_out;
  logic [ResW-1:0]      res_out_vec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  assign full = rec_full;
  assign take = push && !rec_full;

  b93crc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .in_char_i   (in_char_i),
    .last_char_i (last_char_i),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  b93crc_fifo #(
    .WIDTH (RecW),
    .DEPTH (REC_DEPTH)
  ) u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .data_o  (rec_out_vec),
    .empty_o (rec_empty)
  );

  assign rec_out = b93crc_pkg::rec_t'(rec_out_vec);

  b93crc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!rec_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .cap_i       (cap_q),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .res_o       (res_in)
  );

  b93crc_fifo #(
    .WIDTH (ResW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_out_vec),
    .empty_o (empty)
  );

  assign res_out       = b93crc_pkg::result_t'(res_out_vec);
  assign kind_o        = res_out.kind;
  assign data_value_o  = res_out.data;
  assign direction_o   = res_out.dir;
  assign packet_id_o   = res_out.pid;
  assign status_o      = res_out.status;
  assign last_of_run_o = res_out.last_of_run;

endmodule

// File: sv/b93crc_fifo.sv
module b93crc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("fifo count beyond depth");
`endif

endmodule

// File: sv/b93crc_front.sv
module b93crc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        in_char_i,
  input  logic              last_char_i,
  output logic              rec_push_o,
  output b93crc_pkg::rec_t  rec_o
);

  logic [2:0]  digit_cnt_q, digit_cnt_d;
  logic [31:0] group_q, group_d;
  logic [7:0]  char_adj;
  logic [8:0]  digit;
  logic [31:0] product;
  logic [31:0] sum;
  logic        group_done;

  // Characters at or above '+' skip one code point before the base offset.
  assign char_adj = (in_char_i >= b93crc_pkg::CharSkip) ? in_char_i - 8'd1 : in_char_i;
  assign digit    = {1'b0, char_adj} - b93crc_pkg::CharBase;
  assign product  = 32'($signed(digit) * $signed({1'b0, b93crc_pkg::weight93(digit_cnt_q)}));
  assign sum      = group_q + product;
  assign group_done = (digit_cnt_q == b93crc_pkg::LastDigit);

  assign rec_push_o      = take_i && (group_done || last_char_i);
  assign rec_o.group     = sum;
  assign rec_o.has_group = group_done;
  assign rec_o.last      = last_char_i;

  always_comb begin
    digit_cnt_d = digit_cnt_q;
    group_d     = group_q;
    if (take_i) begin
      if (group_done || last_char_i) begin
        digit_cnt_d = '0;
        group_d     = '0;
      end else begin
        digit_cnt_d = digit_cnt_q + 3'd1;
        group_d     = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_cnt_q <= '0;
      group_q     <= '0;
    end else begin
      digit_cnt_q <= digit_cnt_d;
      group_q     <= group_d;
    end
  end

endmodule

// File: sv/b93crc_back.sv
module b93crc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rec_valid_i,
  input  b93crc_pkg::rec_t     rec_i,
  output logic                 rec_pop_o,
  input  logic [8:0]           cap_i,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output b93crc_pkg::result_t  res_o
);

  b93crc_pkg::phase_e phase_q, phase_d;
  logic [2:0] pos_q, pos_d;
  logic [7:0] length_q, length_d;
  logic [7:0] taken_q, taken_d;
  logic [7:0] crc_q, crc_d;
  logic       pend_q, pend_d;

  logic       step, halted, at_tail, byte_last, cap_hit, pay_more, crc_ok;
  logic [2:0] eff_pos;
  logic [7:0] cur_byte;

  assign step      = rec_valid_i && !out_full_i;
  assign halted    = (phase_q == b93crc_pkg::PH_HALT);
  assign eff_pos   = rec_i.has_group ? pos_q : b93crc_pkg::TailPos;
  assign at_tail   = (eff_pos == b93crc_pkg::TailPos);
  assign cur_byte  = 8'(rec_i.group >> {pos_q[1:0], 3'b000});
  assign byte_last = (pos_q[1:0] == 2'd3);
  assign cap_hit   = ({1'b0, cur_byte} >= cap_i);
  assign pay_more  = (taken_q < length_q);
  assign crc_ok    = (cur_byte == ~crc_q);

  // Outputs: at most one result per cycle.
  always_comb begin
    out_push_o = 1'b0;
    rec_pop_o  = 1'b0;
    res_o      = '0;
    if (step) begin
      if (halted) begin
        rec_pop_o = 1'b1;
      end else if (pend_q) begin
        out_push_o        = 1'b1;
        rec_pop_o         = 1'b1;
        res_o.kind        = b93crc_pkg::KIND_STATUS;
        res_o.data        = length_q;
        res_o.status      = b93crc_pkg::ST_TOO_LARGE;
        res_o.last_of_run = 1'b1;
      end else if (at_tail) begin
        out_push_o        = 1'b1;
        rec_pop_o         = 1'b1;
        res_o.kind        = b93crc_pkg::KIND_STATUS;
        res_o.status      = b93crc_pkg::ST_TOO_SHORT;
        res_o.last_of_run = 1'b1;
      end else begin
        out_push_o        = 1'b1;
        res_o.data        = cur_byte;
        res_o.last_of_run = byte_last && !rec_i.last;
        rec_pop_o         = byte_last && !rec_i.last;
        unique case (phase_q)
          b93crc_pkg::PH_HEADER: begin
            res_o.kind = b93crc_pkg::KIND_HEADER;
            res_o.dir  = cur_byte[7];
            res_o.pid  = cur_byte[6:0];
          end
          b93crc_pkg::PH_LENGTH: begin
            res_o.kind = b93crc_pkg::KIND_LENGTH;
            if (cap_hit) begin
              res_o.last_of_run = 1'b0;
              rec_pop_o         = 1'b0;
            end
          end
          b93crc_pkg::PH_PAYLOAD: begin
            if (pay_more) begin
              res_o.kind = b93crc_pkg::KIND_PAYLOAD;
            end else begin
              res_o.kind        = b93crc_pkg::KIND_STATUS;
              res_o.status      = crc_ok ? b93crc_pkg::ST_SUCCESS
                                         : b93crc_pkg::ST_CORRUPTED;
              res_o.last_of_run = 1'b1;
              rec_pop_o         = 1'b1;
            end
          end
          default: begin
            res_o = '0;
          end
        endcase
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    length_d = length_q;
    taken_d  = taken_q;
    crc_d    = crc_q;
    pend_d   = pend_q;
    if (step) begin
      if (halted || pend_q || at_tail) begin
        // The record is finished here: either rearm or stop until the last word.
        pos_d  = '0;
        pend_d = 1'b0;
        if (rec_i.last) begin
          phase_d  = b93crc_pkg::PH_HEADER;
          length_d = '0;
          taken_d  = '0;
          crc_d    = b93crc_pkg::CrcInit;
        end else begin
          phase_d = b93crc_pkg::PH_HALT;
        end
      end else begin
        pos_d = byte_last ? (rec_i.last ? b93crc_pkg::TailPos : 3'd0) : pos_q + 3'd1;
        unique case (phase_q)
          b93crc_pkg::PH_HEADER: begin
            crc_d   = b93crc_pkg::crc8_update(crc_q, cur_byte);
            phase_d = b93crc_pkg::PH_LENGTH;
          end
          b93crc_pkg::PH_LENGTH: begin
            length_d = cur_byte;
            if (cap_hit) begin
              pend_d = 1'b1;
              pos_d  = pos_q;
            end else begin
              crc_d   = b93crc_pkg::crc8_update(crc_q, cur_byte);
              taken_d = '0;
              phase_d = b93crc_pkg::PH_PAYLOAD;
            end
          end
          b93crc_pkg::PH_PAYLOAD: begin
            if (pay_more) begin
              crc_d   = b93crc_pkg::crc8_update(crc_q, cur_byte);
              taken_d = taken_q + 8'd1;
            end else begin
              pos_d = '0;
              if (rec_i.last) begin
                phase_d  = b93crc_pkg::PH_HEADER;
                length_d = '0;
                taken_d  = '0;
                crc_d    = b93crc_pkg::CrcInit;
              end else begin
                phase_d = b93crc_pkg::PH_HALT;
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= b93crc_pkg::PH_HEADER;
      pos_q    <= '0;
      length_q <= '0;
      taken_q  <= '0;
      crc_q    <= b93crc_pkg::CrcInit;
      pend_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      length_q <= length_d;
      taken_q  <= taken_d;
      crc_q    <= crc_d;
      pend_q   <= pend_d;
    end
  end

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == b93crc_pkg::PH_HALT) |-> !out_push_o)
    else $error("result produced while halted");

  a_pend_in_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (phase_q == b93crc_pkg::PH_LENGTH))
    else $error("pending capacity status outside length phase");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= b93crc_pkg::TailPos)
    else $error("byte position out of range");

  a_status_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && res_o.last_of_run) |-> rec_pop_o)
    else $error("run ended without retiring its record");
`endif

endmodule

// File: dv/tb_base93_crc8_packet_decoder_unit.sv
`timescale 1ns / 100ps

module tb_base93_crc8_packet_decoder_unit;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 30;
  localparam int STALL_LIMIT    = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } char_word_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic [7:0] in_char_i   = 8'h00;
  logic       last_char_i = 1'b0;
  logic       pop         = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [8:0] cfg_data_i  = 9'd0;
  logic       full;
  logic       empty;
  logic [1:0] kind_o;
  logic [7:0] data_value_o;
  logic       direction_o;
  logic [6:0] packet_id_o;
  logic [1:0] status_o;
  logic       last_of_run_o;
  logic       cfg_ready_o;

  base93_crc8_packet_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_char_i     (in_char_i),
    .last_char_i   (last_char_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .data_value_o  (data_value_o),
    .direction_o   (direction_o),
    .packet_id_o   (packet_id_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  char_word_t          char_backlog[$];
  b93crc_pkg::result_t pending_results[$];
  logic [7:0]          frame[$];
  logic [7:0]          frame_chars[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  int errors = 0;
  int cfg_writes = 0;
  int chars_queued = 0;
  int stall_cycles = 0;

  // Decoder state as the testbench sees it.
  logic [8:0]          capacity = 9'd256;
  int                  digits_held = 0;
  logic [31:0]         group_acc = '0;
  b93crc_pkg::phase_e  stage = b93crc_pkg::PH_HEADER;
  logic [7:0]          pkt_len = '0;
  logic [7:0]          taken = '0;
  logic [7:0]          crc_acc = 8'hFF;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [8:0] c;
    c = {1'b0, crc ^ b};
    repeat (8) begin
      c = {c[7:0], 1'b0};
      if (c[8]) c = c ^ 9'h01D;
    end
    return c[7:0];
  endfunction

  function automatic logic [31:0] place_weight(input int pos);
    logic [31:0] w;
    w = 32'd1;
    repeat (pos) w = w * 32'd93;
    return w;
  endfunction

  function automatic void rearm_decoder();
    digits_held = 0;
    group_acc   = '0;
    stage       = b93crc_pkg::PH_HEADER;
    pkt_len     = '0;
    taken       = '0;
    crc_acc     = 8'hFF;
  endfunction

  function automatic void add_result(input b93crc_pkg::kind_e k, input logic [7:0] d,
                                     input logic dr, input logic [6:0] id,
                                     input b93crc_pkg::status_e s);
    b93crc_pkg::result_t r;
    r.kind        = k;
    r.data        = d;
    r.dir         = dr;
    r.pid         = id;
    r.status      = s;
    r.last_of_run = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Returns 1 once the byte has produced the packet's final status.
  function automatic bit decode_byte(input logic [7:0] b);
    case (stage)
      b93crc_pkg::PH_HEADER: begin
        add_result(b93crc_pkg::KIND_HEADER, b, b[7], b[6:0], b93crc_pkg::ST_SUCCESS);
        crc_acc = crc8_step(crc_acc, b);
        stage = b93crc_pkg::PH_LENGTH;
        return 1'b0;
      end
      b93crc_pkg::PH_LENGTH: begin
        pkt_len = b;
        add_result(b93crc_pkg::KIND_LENGTH, b, 1'b0, 7'd0, b93crc_pkg::ST_SUCCESS);
        if ({1'b0, b} >= capacity) begin
          add_result(b93crc_pkg::KIND_STATUS, b, 1'b0, 7'd0, b93crc_pkg::ST_TOO_LARGE);
          return 1'b1;
        end
        crc_acc = crc8_step(crc_acc, b);
        taken = '0;
        stage = b93crc_pkg::PH_PAYLOAD;
        return 1'b0;
      end
      default: begin
        if (taken < pkt_len) begin
          add_result(b93crc_pkg::KIND_PAYLOAD, b, 1'b0, 7'd0, b93crc_pkg::ST_SUCCESS);
          crc_acc = crc8_step(crc_acc, b);
          taken = taken + 8'd1;
          return 1'b0;
        end
        if (b == ~crc_acc)
          add_result(b93crc_pkg::KIND_STATUS, b, 1'b0, 7'd0, b93crc_pkg::ST_SUCCESS);
        else
          add_result(b93crc_pkg::KIND_STATUS, b, 1'b0, 7'd0, b93crc_pkg::ST_CORRUPTED);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void predict_char(input logic [7:0] ch, input logic lst);
    logic [7:0]  c;
    logic [31:0] g;
    bit          done;
    int          n_before;
    n_before = pending_results.size();
    done = 1'b0;
    if (stage == b93crc_pkg::PH_HALT) begin
      if (lst) rearm_decoder();
      return;
    end
    c = ch;
    if (c >= b93crc_pkg::CharSkip) c = c - 8'd1;
    group_acc = group_acc
              + ({24'd0, c} - 32'(b93crc_pkg::CharBase)) * place_weight(digits_held);
    digits_held++;
    if (digits_held == 5) begin
      g = group_acc;
      digits_held = 0;
      group_acc = '0;
      for (int i = 0; i < 4 && !done; i++) begin
        done = decode_byte(g[7:0]);
        g = g >> 8;
      end
    end
    if (lst) begin
      if (!done)
        add_result(b93crc_pkg::KIND_STATUS, 8'd0, 1'b0, 7'd0, b93crc_pkg::ST_TOO_SHORT);
      rearm_decoder();
    end else if (done) begin
      stage = b93crc_pkg::PH_HALT;
    end
    if (pending_results.size() > n_before)
      pending_results[pending_results.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  // Driver: offers the oldest queued character at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && char_backlog.size() > 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
      push        <= 1'b1;
      in_char_i   <= char_backlog[0].ch;
      last_char_i <= char_backlog[0].lst;
    end else begin
      push <= 1'b0;
    end
  end

  // Receiver; a hold-off keeps pop low so the block backs up into its input.
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    b93crc_pkg::result_t want;
    if (push && !full) begin
      predict_char(char_backlog[0].ch, char_backlog[0].lst);
      void'(char_backlog.pop_front());
    end
    if (cfg_valid_i && cfg_ready_o) begin
      capacity = cfg_data_i;
      cfg_writes++;
    end
    if (pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with none expected, kind", 0, kind_o);
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind) report_mismatch("kind", want.kind, kind_o);
        if (data_value_o !== want.data) report_mismatch("data_value", want.data, data_value_o);
        if (direction_o !== want.dir) report_mismatch("direction", want.dir, direction_o);
        if (packet_id_o !== want.pid) report_mismatch("packet_id", want.pid, packet_id_o);
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        if (last_of_run_o !== want.last_of_run)
          report_mismatch("last_of_run", want.last_of_run, last_of_run_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void queue_char(input logic [7:0] ch, input logic lst);
    char_word_t w;
    w.ch  = ch;
    w.lst = lst;
    char_backlog.push_back(w);
    chars_queued++;
  endfunction

  // Builds header, length, payload and check byte, pads to whole groups and
  // encodes each group as five base-93 characters, least significant first.
  function automatic void build_frame(input logic [7:0] hdr, input logic [7:0] len,
                                      input int n_payload, input bit crc_ok);
    logic [7:0]  crc;
    logic [7:0]  b;
    logic [31:0] word;
    logic [31:0] digit;
    logic [7:0]  ch;
    frame.delete();
    frame_chars.delete();
    frame.push_back(hdr);
    frame.push_back(len);
    crc = crc8_step(crc8_step(8'hFF, hdr), len);
    repeat (n_payload) begin
      b = 8'($urandom);
      frame.push_back(b);
      crc = crc8_step(crc, b);
    end
    crc = ~crc;
    if (!crc_ok) crc = crc ^ 8'($urandom_range(255, 1));
    frame.push_back(crc);
    while (frame.size() % 4 != 0) frame.push_back(8'($urandom));
    for (int k = 0; k < frame.size(); k += 4) begin
      word = {frame[k + 3], frame[k + 2], frame[k + 1], frame[k]};
      repeat (5) begin
        digit = word % 32'd93;
        word  = word / 32'd93;
        ch    = 8'(digit + 32'(b93crc_pkg::CharBase));
        if (ch >= b93crc_pkg::CharSkip) ch = ch + 8'd1;
        frame_chars.push_back(ch);
      end
    end
  endfunction

  function automatic void queue_frame(input bit mark_last);
    for (int k = 0; k < frame_chars.size(); k++)
      queue_char(frame_chars[k], mark_last && (k == frame_chars.size() - 1));
  endfunction

  // One received buffer: mostly well-formed packets, some broken or noise.
  function automatic void queue_random_buffer();
    int         pick;
    int         cut;
    logic [7:0] len;
    pick = $urandom_range(99, 0);
    if (pick < 15) begin
      repeat ($urandom_range(11, 0)) queue_char(8'($urandom), 1'b0);
      queue_char(8'($urandom), 1'b1);
      return;
    end
    len = ($urandom_range(39, 0) == 0) ? 8'($urandom) : 8'($urandom_range(24, 0));
    build_frame(8'($urandom), len, len, $urandom_range(99, 0) >= 15);
    if (pick < 25) begin
      frame_chars[$urandom_range(frame_chars.size() - 1, 0)] = 8'($urandom);
    end else if (pick < 40) begin
      cut = $urandom_range(frame_chars.size() - 1, 1);
      while (frame_chars.size() > cut) void'(frame_chars.pop_back());
    end
    if (pick >= 40 && pick < 50) begin
      // Characters after the status are swallowed until the marked one.
      queue_frame(1'b0);
      repeat ($urandom_range(6, 1)) queue_char(8'($urandom), 1'b0);
      queue_char(8'($urandom), 1'b1);
    end else begin
      queue_frame(!(pick >= 50 && pick < 55));
    end
  endfunction

  task automatic queue_random(input int n_chars);
    int target;
    target = chars_queued + n_chars;
    while (chars_queued < target) queue_random_buffer();
  endtask

  task automatic wait_until_drained();
    while (char_backlog.size() != 0 || pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [8:0] value);
    int seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    while (cfg_writes == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [8:0] cap_mid;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 34;
    rx_idle_pct = 52;

    // A lone character, marked last, ends the buffer early.
    queue_char(8'h00, 1'b1);
    queue_char(8'hFF, 1'b1);
    queue_char(b93crc_pkg::CharSkip, 1'b1);
    // Empty payload with a good check byte, header bits all ones.
    build_frame(8'hFF, 8'd0, 0, 1'b1);
    queue_frame(1'b1);
    // Bad check byte on an unmarked character, then characters while halted.
    build_frame(8'h00, 8'd1, 1, 1'b0);
    queue_frame(1'b0);
    queue_char(b93crc_pkg::CharSkip - 8'd1, 1'b0);
    queue_char(8'h7E, 1'b1);
    queue_random(60);
    wait_until_drained();

    write_capacity(9'd0);
    queue_random(30);
    wait_until_drained();

    tx_idle_pct = 52;
    rx_idle_pct = 34;
    write_capacity(9'd1);
    queue_random(30);
    wait_until_drained();

    cap_mid = 9'($urandom_range(20, 2));
    write_capacity(cap_mid);
    build_frame(8'($urandom), 8'(cap_mid - 9'd1), int'(cap_mid) - 1, 1'b1);
    queue_frame(1'b1);
    build_frame(8'($urandom), 8'(cap_mid), int'(cap_mid), 1'b1);
    queue_frame(1'b1);
    queue_random(40);
    wait_until_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_capacity(9'd255);
    build_frame(8'($urandom), 8'd255, 2, 1'b1);
    queue_frame(1'b1);
    rx_hold_left = RX_HOLD_CYCLES;
    queue_random(40);
    wait_until_drained();

    write_capacity(9'd256);
    queue_random(40);
    wait_until_drained();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
